[hw/rtl/thas_pkg.sv]
package thas_pkg;

  // default coordinate format
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // scaled vector components stay below 2^NORM_BITS
  localparam int NORM_BITS = 20;
  localparam int SQ_W      = 2 * NORM_BITS + 2;   // squared norms, |dot|
  localparam int ROOT_W    = NORM_BITS + 1;       // integer square roots
  localparam int QUO_W     = 16;                  // sine quotient, Q0.16
  localparam int SIN_STEPS = 255;
  localparam int SIN_W     = 32;
  localparam int STEP_W    = 8;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SIN_STEPS - 1);
  localparam logic [STEP_W-1:0] SHADE_MAX = 8'd255;

  localparam longint unsigned PI_Q30 = 64'd3373259426;

  typedef enum logic [2:0] {
    REQ_ORIGIN = 3'd0,
    REQ_DIR    = 3'd1,
    REQ_VERT1  = 3'd2,
    REQ_VERT2  = 3'd3,
    REQ_HIT    = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    CFG_LIGHT_X = 2'd0,
    CFG_LIGHT_Y = 2'd1,
    CFG_LIGHT_Z = 2'd2
  } cfg_reg_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PMUL,
    ST_PADD,
    ST_DIFF,
    ST_SCALE,
    ST_XMUL,
    ST_XACC,
    ST_DMUL,
    ST_DACC,
    ST_SQL,
    ST_SQLW,
    ST_SQN,
    ST_SQNW,
    ST_RMUL,
    ST_RCHK,
    ST_DIV,
    ST_SRCH,
    ST_FIN
  } state_t;

  // square root unit handshake
  typedef struct packed {
    logic              start;
    logic [SQ_W-1:0]   rad;
  } sqrt_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_rsp_t;

  // sin(k*pi/510) in Q2.30, odd Taylor series to the 13th power
  function automatic logic [SIN_STEPS*SIN_W-1:0] sin_table();
    logic [SIN_STEPS*SIN_W-1:0] tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    int k;
    tab = '0;
    for (k = 0; k < SIN_STEPS; k++) begin
      x    = (64'(k) * PI_Q30) / 64'd510;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + term;
      tab[k*SIN_W +: SIN_W] = SIN_W'(sum);
    end
    return tab;
  endfunction

  localparam logic [SIN_STEPS*SIN_W-1:0] SIN_TAB = sin_table();

endpackage

[hw/rtl/thas_mul.sv]
module thas_mul
  import thas_pkg::*;
#(
  parameter int MW = COORD_WIDTH_DEF
) (
  input  logic            clk,
  input  logic [MW-1:0]   a,
  input  logic [MW-1:0]   b,
  output logic [2*MW-1:0] prod
);

  // shared unsigned multiplier, product registered
  always_ff @(posedge clk) begin
    prod <= (2*MW)'(a) * (2*MW)'(b);
  end

endmodule

[hw/rtl/thas_isqrt.sv]
module thas_isqrt
  import thas_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  sqrt_req_t req,
  output sqrt_rsp_t rsp
);

  logic            busy;
  logic [SQ_W-1:0] x;
  logic [SQ_W:0]   r;
  logic [SQ_W-1:0] bitv;
  logic [SQ_W:0]   trial;
  logic            done;

  assign trial = r + (SQ_W+1)'(bitv);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && bitv[0]) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // one result bit per cycle, restoring digit recurrence
  always_ff @(posedge clk) begin
    if (req.start) begin
      x    <= req.rad;
      r    <= '0;
      bitv <= SQ_W'(1) << (SQ_W - 2);
    end else if (busy) begin
      if ((SQ_W+1)'(x) >= trial) begin
        x <= SQ_W'((SQ_W+1)'(x) - trial);
        r <= (r >> 1) + (SQ_W+1)'(bitv);
      end else begin
        r <= r >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

  assign rsp.done = done;
  assign rsp.root = r[ROOT_W-1:0];

endmodule

[hw/rtl/triangle_hit_angle_shader.sv]
// Triangle hit angle shader. Load transactions (origin, direction, vertex
// one, vertex two) are taken while the block is idle; unknown request
// codes are dropped. A hit transaction whose u/v test fails goes straight
// to the final state, which puts a zero result in the output register. A
// passing hit runs a small sequencer around one shared multiplier: hit
// point, difference vectors, magnitude normalization of the light and
// edge vectors (shifting one bit at a time), cross product, normalization
// of the normal, dot and squared norms, two bit-serial square roots, root
// product and range check, division, a binary search over a 255-entry
// sine table and the load of the output register. in_stall is high until
// the result is in the output register; a result waiting there does not
// block new input.
module triangle_hit_angle_shader
  import thas_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_addr,
  input  logic [COORD_WIDTH-1:0] cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [2:0]             req_type,
  input  logic [COORD_WIDTH-1:0] comp_a,
  input  logic [COORD_WIDTH-1:0] comp_b,
  input  logic [COORD_WIDTH-1:0] comp_c,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             shade,
  output logic                   opaque
);

  localparam int W   = COORD_WIDTH;
  localparam int MW  = (W > ROOT_W) ? W : ROOT_W;
  localparam int PW  = 2 * MW;
  localparam int MGW = (W > 2*NORM_BITS+1) ? W : 2*NORM_BITS+1;
  localparam int XW  = 2 * NORM_BITS + 3;
  localparam int PRW = 2 * NORM_BITS;
  localparam logic [W:0] ONE_FX = (W+1)'(1) << FRAC_BITS;

  state_t state, state_next;
  logic [3:0] op;
  logic [1:0] vsel;

  logic signed [W-1:0] org [3];
  logic signed [W-1:0] dir [3];
  logic signed [W-1:0] vt1 [3];
  logic signed [W-1:0] vt2 [3];
  logic signed [W-1:0] lit [3];
  logic signed [W-1:0] pt  [3];
  logic signed [W-1:0] t_r;

  // vectors: 0 light, 1 to vertex one, 2 to vertex two, 3 normal
  logic [MGW-1:0] vmag [4][3];
  logic           vneg [4][3];

  logic [MW-1:0] mul_a, mul_b;
  logic [PW-1:0] prod;
  logic          prod_neg, op_neg;

  logic signed [XW-1:0] xacc, dacc;
  logic [SQ_W-1:0]      sl, sn, pr, dmag;
  logic [SQ_W:0]        rem, rem_sh;
  logic [QUO_W-1:0]     quo;
  logic [ROOT_W-1:0]    rl, rn;
  logic [STEP_W-1:0]    lo, hi, mid;
  logic [STEP_W:0]      mid_sum;
  logic [7:0]           res_shade;
  logic                 res_opaque;

  sqrt_req_t sq_req;
  sqrt_rsp_t sq_rsp;

  logic in_acc, out_acc, out_free, hit_ok;
  logic [1:0] ix, xa, xb, dja, djb, dva, dvb;
  logic       xsub;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign out_free = !out_valid || !out_stall;
  assign ix       = op[1:0];

  // u > 0, v > 0, u + v <= 1
  always_comb begin
    hit_ok = !comp_b[W-1] && (comp_b != '0) && !comp_c[W-1] && (comp_c != '0) &&
             (({1'b0, comp_b} + {1'b0, comp_c}) <= ONE_FX);
  end

  // hit point: o + floor(t*d / 2^F), saturated
  logic [PW-FRAC_BITS-1:0] pq;
  logic                    prem_nz, pbig;
  logic [W:0]              pqc;
  logic signed [W+1:0]     pmf;
  logic signed [W+2:0]     psum;
  logic signed [W-1:0]     pnew;

  always_comb begin
    pq      = prod[PW-1:FRAC_BITS];
    prem_nz = |prod[FRAC_BITS-1:0];
    pbig    = (pq >> W) != '0;
    if (pbig) begin
      pqc = (W+1)'(1) << W;
    end else begin
      pqc = {1'b0, pq[W-1:0]} + (W+1)'(prod_neg && prem_nz);
    end
    pmf  = prod_neg ? -$signed({1'b0, pqc}) : $signed({1'b0, pqc});
    psum = (W+3)'(org[ix]) + (W+3)'(pmf);
    if (psum[W+2:W-1] == '0 || psum[W+2:W-1] == '1) begin
      pnew = psum[W-1:0];
    end else if (psum[W+2]) begin
      pnew = {1'b1, {(W-1){1'b0}}};
    end else begin
      pnew = {1'b0, {(W-1){1'b1}}};
    end
  end

  // difference vectors for one component
  logic signed [W:0] dl, de1, de2;
  logic [W:0]        ml, me1, me2;

  always_comb begin
    dl  = (W+1)'(pt[ix]) - (W+1)'(lit[ix]);
    de1 = (W+1)'(vt1[ix]) - (W+1)'(pt[ix]);
    de2 = (W+1)'(vt2[ix]) - (W+1)'(pt[ix]);
    ml  = dl[W]  ? -dl  : dl;
    me1 = de1[W] ? -de1 : de1;
    me2 = de2[W] ? -de2 : de2;
  end

  // normalization test on the selected vector
  logic [MGW-1:0] vor;
  logic           scale_more;

  always_comb begin
    vor        = vmag[vsel][0] | vmag[vsel][1] | vmag[vsel][2];
    scale_more = (vor >> NORM_BITS) != '0;
  end

  // cross product operand pairs: component op/2, subtract on odd op
  always_comb begin
    unique case (op)
      4'd0:    begin xa = 2'd1; xb = 2'd2; xsub = 1'b0; end
      4'd1:    begin xa = 2'd2; xb = 2'd1; xsub = 1'b1; end
      4'd2:    begin xa = 2'd2; xb = 2'd0; xsub = 1'b0; end
      4'd3:    begin xa = 2'd0; xb = 2'd2; xsub = 1'b1; end
      4'd4:    begin xa = 2'd0; xb = 2'd1; xsub = 1'b0; end
      4'd5:    begin xa = 2'd1; xb = 2'd0; xsub = 1'b1; end
      default: begin xa = 2'd0; xb = 2'd0; xsub = 1'b0; end
    endcase
  end

  // dot and squared norm operands: L.n, L.L, n.n
  always_comb begin
    unique case (op)
      4'd0:    begin dva = 2'd0; dja = 2'd0; dvb = 2'd3; djb = 2'd0; end
      4'd1:    begin dva = 2'd0; dja = 2'd1; dvb = 2'd3; djb = 2'd1; end
      4'd2:    begin dva = 2'd0; dja = 2'd2; dvb = 2'd3; djb = 2'd2; end
      4'd3:    begin dva = 2'd0; dja = 2'd0; dvb = 2'd0; djb = 2'd0; end
      4'd4:    begin dva = 2'd0; dja = 2'd1; dvb = 2'd0; djb = 2'd1; end
      4'd5:    begin dva = 2'd0; dja = 2'd2; dvb = 2'd0; djb = 2'd2; end
      4'd6:    begin dva = 2'd3; dja = 2'd0; dvb = 2'd3; djb = 2'd0; end
      4'd7:    begin dva = 2'd3; dja = 2'd1; dvb = 2'd3; djb = 2'd1; end
      4'd8:    begin dva = 2'd3; dja = 2'd2; dvb = 2'd3; djb = 2'd2; end
      default: begin dva = 2'd0; dja = 2'd0; dvb = 2'd0; djb = 2'd0; end
    endcase
  end

  // accumulate terms
  logic signed [XW-1:0] pterm, xsum, xabs;

  always_comb begin
    pterm = prod_neg ? -$signed(XW'(prod[PRW-1:0])) : $signed(XW'(prod[PRW-1:0]));
    xsum  = xacc + pterm;
    xabs  = xsum[XW-1] ? -xsum : xsum;
    dmag  = dacc[XW-1] ? SQ_W'(-dacc) : SQ_W'(dacc);
  end

  // divide and search steps
  always_comb begin
    rem_sh  = {rem[SQ_W-1:0], 1'b0};
    mid_sum = (STEP_W+1)'(lo) + (STEP_W+1)'(hi) + (STEP_W+1)'(1);
    mid     = mid_sum[STEP_W:1];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && req_type == REQ_HIT) begin
          state_next = hit_ok ? ST_PMUL : ST_FIN;
        end
      end
      ST_PMUL: state_next = ST_PADD;
      ST_PADD: state_next = (op == 4'd2) ? ST_DIFF : ST_PMUL;
      ST_DIFF: state_next = (op == 4'd2) ? ST_SCALE : ST_DIFF;
      ST_SCALE: begin
        if (!scale_more) begin
          if (vsel == 2'd2) begin
            state_next = ST_XMUL;
          end else if (vsel == 2'd3) begin
            state_next = ST_DMUL;
          end
        end
      end
      ST_XMUL: state_next = ST_XACC;
      ST_XACC: state_next = (op == 4'd5) ? ST_SCALE : ST_XMUL;
      ST_DMUL: state_next = ST_DACC;
      ST_DACC: state_next = (op == 4'd8) ? ST_SQL : ST_DMUL;
      ST_SQL:  state_next = ST_SQLW;
      ST_SQLW: state_next = sq_rsp.done ? ST_SQN : ST_SQLW;
      ST_SQN:  state_next = ST_SQNW;
      ST_SQNW: state_next = sq_rsp.done ? ST_RMUL : ST_SQNW;
      ST_RMUL: state_next = ST_RCHK;
      ST_RCHK: begin
        if (prod[SQ_W-1:0] == '0 || !dacc[XW-1] || dmag >= prod[SQ_W-1:0]) begin
          state_next = ST_FIN;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DIV:  state_next = (op == 4'd15) ? ST_SRCH : ST_DIV;
      ST_SRCH: state_next = (lo >= hi) ? ST_FIN : ST_SRCH;
      ST_FIN:  state_next = out_free ? ST_IDLE : ST_FIN;
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs: handshake, multiplier operands, root unit
  always_comb begin
    in_stall   = 1'b1;
    mul_a      = '0;
    mul_b      = '0;
    op_neg     = 1'b0;
    sq_req     = '0;
    unique case (state)
      ST_IDLE: in_stall = 1'b0;
      ST_PMUL: begin
        mul_a  = MW'(t_r[W-1] ? -t_r : t_r);
        mul_b  = MW'(dir[ix][W-1] ? -dir[ix] : dir[ix]);
        op_neg = t_r[W-1] ^ dir[ix][W-1];
      end
      ST_XMUL: begin
        mul_a  = MW'(vmag[1][xa][NORM_BITS-1:0]);
        mul_b  = MW'(vmag[2][xb][NORM_BITS-1:0]);
        op_neg = vneg[1][xa] ^ vneg[2][xb] ^ xsub;
      end
      ST_DMUL: begin
        mul_a  = MW'(vmag[dva][dja][NORM_BITS-1:0]);
        mul_b  = MW'(vmag[dvb][djb][NORM_BITS-1:0]);
        op_neg = (op < 4'd3) && (vneg[dva][dja] ^ vneg[dvb][djb]);
      end
      ST_SQL: begin
        sq_req.start = 1'b1;
        sq_req.rad   = sl;
      end
      ST_SQN: begin
        sq_req.start = 1'b1;
        sq_req.rad   = sn;
      end
      ST_RMUL: begin
        mul_a = MW'(rl);
        mul_b = MW'(rn);
      end
      default: ;
    endcase
  end

  thas_mul #(.MW(MW)) u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  thas_isqrt u_isqrt (
    .clk (clk),
    .rst (rst),
    .req (sq_req),
    .rsp (sq_rsp)
  );

  // control, loaded geometry and light registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      op        <= '0;
      vsel      <= '0;
      out_valid <= 1'b0;
      for (int j = 0; j < 3; j++) begin
        org[j] <= '0;
        dir[j] <= '0;
        vt1[j] <= '0;
        vt2[j] <= '0;
        lit[j] <= '0;
      end
    end else begin
      state <= state_next;

      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_addr))
          CFG_LIGHT_X: lit[0] <= cfg_data;
          CFG_LIGHT_Y: lit[1] <= cfg_data;
          CFG_LIGHT_Z: lit[2] <= cfg_data;
          default: ;
        endcase
      end

      if (state == ST_IDLE && in_acc) begin
        unique case (req_t'(req_type))
          REQ_ORIGIN: begin org[0] <= comp_a; org[1] <= comp_b; org[2] <= comp_c; end
          REQ_DIR:    begin dir[0] <= comp_a; dir[1] <= comp_b; dir[2] <= comp_c; end
          REQ_VERT1:  begin vt1[0] <= comp_a; vt1[1] <= comp_b; vt1[2] <= comp_c; end
          REQ_VERT2:  begin vt2[0] <= comp_a; vt2[1] <= comp_b; vt2[2] <= comp_c; end
          default: ;
        endcase
      end

      // step counter and vector select
      unique case (state)
        ST_IDLE: op <= '0;
        ST_PADD: op <= (op == 4'd2) ? '0 : op + 4'd1;
        ST_DIFF: begin
          op <= (op == 4'd2) ? '0 : op + 4'd1;
          if (op == 4'd2) begin
            vsel <= '0;
          end
        end
        ST_SCALE: begin
          if (!scale_more) begin
            op <= '0;
            if (vsel < 2'd2) begin
              vsel <= vsel + 2'd1;
            end
          end
        end
        ST_XACC: begin
          op <= (op == 4'd5) ? '0 : op + 4'd1;
          if (op == 4'd5) begin
            vsel <= 2'd3;
          end
        end
        ST_DACC: op <= (op == 4'd8) ? '0 : op + 4'd1;
        ST_RCHK: op <= '0;
        ST_DIV:  op <= op + 4'd1;
        default: ;
      endcase

      // output register
      if (state == ST_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_acc) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_acc && req_type == REQ_HIT) begin
          t_r        <= comp_a;
          res_shade  <= '0;
          res_opaque <= hit_ok;
        end
      end
      ST_PMUL: prod_neg <= op_neg;
      ST_PADD: pt[ix] <= pnew;
      ST_DIFF: begin
        vmag[0][ix] <= MGW'(ml[W-1:0]);
        vneg[0][ix] <= dl[W];
        vmag[1][ix] <= MGW'(me1[W-1:0]);
        vneg[1][ix] <= de1[W];
        vmag[2][ix] <= MGW'(me2[W-1:0]);
        vneg[2][ix] <= de2[W];
      end
      ST_SCALE: begin
        if (scale_more) begin
          for (int j = 0; j < 3; j++) begin
            vmag[vsel][j] <= vmag[vsel][j] >> 1;
          end
        end else if (vsel == 2'd1) begin
          xacc <= '0;
        end else if (vsel == 2'd3) begin
          dacc <= '0;
          sl   <= '0;
          sn   <= '0;
        end
      end
      ST_XMUL: prod_neg <= op_neg;
      ST_XACC: begin
        if (op[0]) begin
          vmag[3][op[2:1]] <= MGW'(xabs);
          vneg[3][op[2:1]] <= xsum[XW-1];
          xacc             <= '0;
        end else begin
          xacc <= xsum;
        end
      end
      ST_DMUL: prod_neg <= op_neg;
      ST_DACC: begin
        if (op < 4'd3) begin
          dacc <= dacc + pterm;
        end else if (op < 4'd6) begin
          sl <= sl + SQ_W'(prod[PRW-1:0]);
        end else begin
          sn <= sn + SQ_W'(prod[PRW-1:0]);
        end
      end
      ST_SQLW: begin
        if (sq_rsp.done) begin
          rl <= sq_rsp.root;
        end
      end
      ST_SQNW: begin
        if (sq_rsp.done) begin
          rn <= sq_rsp.root;
        end
      end
      ST_RCHK: begin
        pr  <= prod[SQ_W-1:0];
        rem <= {1'b0, dmag};
        quo <= '0;
        lo  <= '0;
        hi  <= STEP_LAST;
        if (prod[SQ_W-1:0] != '0 && dacc[XW-1] && dmag >= prod[SQ_W-1:0]) begin
          res_shade <= SHADE_MAX;
        end
      end
      ST_DIV: begin
        if (rem_sh >= {1'b0, pr}) begin
          rem <= rem_sh - {1'b0, pr};
          quo <= {quo[QUO_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[QUO_W-2:0], 1'b0};
        end
      end
      ST_SRCH: begin
        if (lo < hi) begin
          if (SIN_TAB[mid*SIN_W +: SIN_W] <= SIN_W'({quo, 14'b0})) begin
            lo <= mid;
          end else begin
            hi <= mid - STEP_W'(1);
          end
        end else begin
          res_shade <= lo;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          shade  <= res_shade;
          opaque <= res_opaque;
        end
      end
      default: ;
    endcase
  end

endmodule

[verif/triangle_hit_angle_shader_test.sv]
`timescale 1ns / 1ps

module triangle_hit_angle_shader_test;
  import thas_pkg::*;

  localparam int  CW          = 32;
  localparam int  CLK_HALF    = 6;
  localparam int  CYCLE_LIMIT = 1500000;
  localparam int  DRAIN_WAIT  = 300;
  localparam int  HOLD_CYCLES = 400;
  localparam int  RAND_ITEMS  = 300;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam longint ONE_FX  = 64'sd65536;
  localparam logic [CW-1:0] CMAX = 32'h7fff_ffff;
  localparam logic [CW-1:0] CMIN = 32'h8000_0000;

  typedef longint vec_t[3];

  typedef struct {
    logic [7:0] shade;
    logic       opaque;
  } pixel_t;

  // shade predictor and store of expected pixels
  class shade_scoreboard;
    longint          light[3];
    vec_t            org, dir, vt1, vt2;
    longint          sin_q30[SIN_STEPS];
    pixel_t          pending[$];
    int              errors;

    function new();
      longint unsigned x, x2, term;
      longint          sum;
      for (int k = 0; k < SIN_STEPS; k++) begin
        x    = (64'(k) * PI_Q30) / 64'd510;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 6; n++) begin
          term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
          if (n % 2 == 1) sum = sum - longint'(term);
          else sum = sum + longint'(term);
        end
        sin_q30[k] = sum;
      end
      for (int i = 0; i < 3; i++) begin
        light[i] = 0; org[i] = 0; dir[i] = 0; vt1[i] = 0; vt2[i] = 0;
      end
      errors = 0;
    endfunction

    function void set_light(logic [1:0] idx, logic [CW-1:0] val);
      if (idx == CFG_LIGHT_X) light[0] = longint'($signed(val));
      else if (idx == CFG_LIGHT_Y) light[1] = longint'($signed(val));
      else if (idx == CFG_LIGHT_Z) light[2] = longint'($signed(val));
    endfunction

    // floor(a*b / 2^16), magnitude capped at 2^32
    function longint mulfx(longint a, longint b);
      longint unsigned ma, mb, pr, q;
      bit neg;
      ma  = a < 0 ? -a : a;
      mb  = b < 0 ? -b : b;
      neg = (a < 0) != (b < 0);
      pr  = ma * mb;
      q   = pr >> 16;
      if (q >= 64'h1_0000_0000) q = 64'h1_0000_0000;
      else if (neg && pr[15:0] != 0) q = q + 1;
      return neg ? -longint'(q) : longint'(q);
    endfunction

    // common shift so every magnitude is below 2^20
    function void shrink(ref vec_t v);
      longint unsigned m, mg[3];
      int s;
      m = 0;
      s = 0;
      for (int i = 0; i < 3; i++) begin
        mg[i] = v[i] < 0 ? -v[i] : v[i];
        if (mg[i] > m) m = mg[i];
      end
      while ((m >> s) >= 64'd1048576) s++;
      for (int i = 0; i < 3; i++)
        v[i] = v[i] < 0 ? -longint'(mg[i] >> s) : longint'(mg[i] >> s);
    endfunction

    function longint unsigned isqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function pixel_t shade_hit(longint t, longint u, longint w);
      pixel_t px;
      vec_t lv, e1, e2, nv;
      longint q, dot;
      longint unsigned sl, sn, pr, m, s;
      int lo, hi, mid;
      px.shade  = 8'd0;
      px.opaque = 1'b0;
      if (!(u > 0 && w > 0 && u + w <= ONE_FX)) return px;
      px.opaque = 1'b1;
      for (int i = 0; i < 3; i++) begin
        q = org[i] + mulfx(t, dir[i]);
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        lv[i] = q - light[i];
        e1[i] = vt1[i] - q;
        e2[i] = vt2[i] - q;
      end
      shrink(lv);
      shrink(e1);
      shrink(e2);
      nv[0] = e1[1] * e2[2] - e1[2] * e2[1];
      nv[1] = e1[2] * e2[0] - e1[0] * e2[2];
      nv[2] = e1[0] * e2[1] - e1[1] * e2[0];
      shrink(nv);
      dot = 0; sl = 0; sn = 0;
      for (int i = 0; i < 3; i++) begin
        dot = dot + lv[i] * nv[i];
        sl  = sl + longint'(lv[i] * lv[i]);
        sn  = sn + longint'(nv[i] * nv[i]);
      end
      pr = isqrt(sl) * isqrt(sn);
      if (pr == 0 || dot >= 0) return px;
      m = -dot;
      s = (m << 16) / pr;
      if (s >= 64'd65536) begin
        px.shade = SHADE_MAX;
      end else begin
        // largest step whose sine stays at or below s
        lo = 0;
        hi = SIN_STEPS - 1;
        while (lo < hi) begin
          mid = (lo + hi + 1) / 2;
          if (sin_q30[mid] <= longint'(s << 14)) lo = mid;
          else hi = mid - 1;
        end
        px.shade = 8'(lo);
      end
      return px;
    endfunction

    function void note(logic [2:0] kind, logic [CW-1:0] a, logic [CW-1:0] b,
                       logic [CW-1:0] c);
      vec_t v;
      v[0] = longint'($signed(a));
      v[1] = longint'($signed(b));
      v[2] = longint'($signed(c));
      case (kind)
        REQ_ORIGIN: org = v;
        REQ_DIR:    dir = v;
        REQ_VERT1:  vt1 = v;
        REQ_VERT2:  vt2 = v;
        REQ_HIT:    pending.push_back(shade_hit(v[0], v[1], v[2]));
        default: ;
      endcase
    endfunction

    function void check(logic [7:0] sh, logic op);
      pixel_t px;
      if (pending.size() == 0) begin
        $display("%0t: unexpected pixel shade %0d opaque %0b", $time, sh, op);
        errors++;
        return;
      end
      px = pending.pop_front();
      if (sh !== px.shade) begin
        $display("%0t: shade expected %0d actual %0d", $time, px.shade, sh);
        errors++;
      end
      if (op !== px.opaque) begin
        $display("%0t: opaque expected %0b actual %0b", $time, px.opaque, op);
        errors++;
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_we = 1'b0;
  logic [1:0]    cfg_addr = '0;
  logic [CW-1:0] cfg_data = '0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [2:0]    req_type = '0;
  logic [CW-1:0] comp_a = '0;
  logic [CW-1:0] comp_b = '0;
  logic [CW-1:0] comp_c = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [7:0]    shade;
  logic          opaque;

  shade_scoreboard sb = new();
  int  tx_pct = 0;
  int  rx_pct = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int  hold_cnt = 0;
  int  cycles = 0;

  triangle_hit_angle_shader u_dut (
    .clk, .rst, .cfg_we, .cfg_addr, .cfg_data,
    .in_valid, .in_stall, .req_type, .comp_a, .comp_b, .comp_c,
    .out_valid, .out_stall, .shade, .opaque
  );

  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  // receiver stall, with one long hold-off on request
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt  <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check(shade, opaque);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL triangle_hit_angle_shader");
      $finish;
    end
  end

  // one input transaction, with random idle cycles ahead of it
  task automatic send(logic [2:0] kind, logic [CW-1:0] a, logic [CW-1:0] b,
                      logic [CW-1:0] c);
    while ($urandom_range(99) < tx_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    comp_a   <= a;
    comp_b   <= b;
    comp_c   <= c;
    do @(posedge clk); while (in_stall);
    sb.note(kind, a, b, c);
  endtask

  // wait for the block to drain, then write the light position
  task automatic set_lights(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_we <= 1'b1; cfg_addr <= CFG_LIGHT_X; cfg_data <= x;
    @(posedge clk);
    sb.set_light(CFG_LIGHT_X, x);
    cfg_addr <= CFG_LIGHT_Y; cfg_data <= y;
    @(posedge clk);
    sb.set_light(CFG_LIGHT_Y, y);
    cfg_addr <= CFG_LIGHT_Z; cfg_data <= z;
    @(posedge clk);
    sb.set_light(CFG_LIGHT_Z, z);
    cfg_addr <= CFG_UNUSED; cfg_data <= $urandom;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly modest coordinates so the geometry stays meaningful
  function automatic logic [CW-1:0] rand_coord();
    if ($urandom_range(99) < 20) return $urandom;
    return CW'($urandom_range(32'h0040_0000) - 32'h0020_0000);
  endfunction

  // origin, direction and two vertices, each sent most of the time, then one to four hits
  task automatic send_frame();
    int hits;
    logic [CW-1:0] u, v, t;
    for (int k = 0; k < 4; k++)
      if ($urandom_range(9) != 0)
        send(3'(k), rand_coord(), rand_coord(), rand_coord());
    hits = $urandom_range(1, 4);
    for (int h = 0; h < hits; h++) begin
      t = ($urandom_range(9) == 0) ? $urandom : CW'($urandom_range(32'h0008_0000));
      if ($urandom_range(99) < 85) begin
        u = $urandom_range(1, 65535);
        v = $urandom_range(1, 65536 - u);
      end else begin
        u = ($urandom_range(1) != 0) ? $urandom : CW'($urandom_range(65536));
        v = ($urandom_range(1) != 0) ? $urandom : CW'($urandom_range(65536));
      end
      send(REQ_HIT, t, u, v);
    end
  endtask

  task automatic random_phase(int items);
    int sent;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(9) == 0) begin
        send(3'($urandom_range(7)), $urandom, $urandom, $urandom);
        sent++;
      end else begin
        send_frame();
        sent += 6;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, misses, unknown codes, zero norm, right geometry
    set_lights('0, '0, '0);
    send(REQ_ORIGIN, CMAX, CMIN, CMAX);
    send(REQ_DIR, CMIN, CMAX, CMIN);
    send(REQ_VERT1, CMAX, CMAX, CMIN);
    send(REQ_VERT2, CMIN, CMIN, CMAX);
    send(REQ_HIT, CMAX, 32'd1, 32'd1);
    send(REQ_HIT, CMIN, 32'd32768, 32'd32768);
    send(REQ_HIT, 32'd65536, 32'd0, 32'd100);
    send(REQ_HIT, 32'd65536, 32'd100, 32'hffff_ffff);
    send(REQ_HIT, 32'd65536, 32'd32769, 32'd32768);
    send(3'd5, $urandom, $urandom, $urandom);
    send(3'd6, $urandom, $urandom, $urandom);
    send(3'd7, $urandom, $urandom, $urandom);
    send(REQ_ORIGIN, '0, '0, '0);
    send(REQ_DIR, '0, '0, '0);
    send(REQ_VERT1, '0, '0, '0);
    send(REQ_VERT2, '0, '0, '0);
    send(REQ_HIT, '0, 32'd1, 32'd1);
    send(REQ_DIR, '0, '0, 32'hffff_0000);
    send(REQ_VERT1, 32'h0001_0000, '0, 32'hffff_0000);
    send(REQ_VERT2, '0, 32'h0001_0000, 32'hffff_0000);
    send(REQ_HIT, 32'h0001_0000, 32'd16384, 32'd16384);
    send(REQ_VERT1, '0, 32'h0001_0000, 32'hffff_0000);
    send(REQ_VERT2, 32'h0001_0000, '0, 32'hffff_0000);
    send(REQ_HIT, 32'h0001_0000, 32'd16384, 32'd16384);

    // random phases with changing idle patterns and light positions
    set_lights(rand_coord(), rand_coord(), rand_coord());
    tx_pct = 34; rx_pct = 65;
    hold_req <= 1'b1;
    random_phase(RAND_ITEMS);
    set_lights(CMAX, CMIN, CMAX);
    tx_pct = 65; rx_pct = 34;
    random_phase(RAND_ITEMS);
    set_lights(CMIN, CMAX, CMIN);
    tx_pct = 0; rx_pct = 0;
    random_phase(RAND_ITEMS / 2);
    set_lights(rand_coord(), rand_coord(), rand_coord());
    random_phase(RAND_ITEMS / 2);

    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS triangle_hit_angle_shader");
    end else begin
      $display("FAIL triangle_hit_angle_shader");
    end
    $finish;
  end

endmodule
